// ===== design/cltlp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cltlp_pkg
// Shared constants and controller/datapath link types for the comma list
// to length-prefixed list encoder.
// ----------------------------------------------------------------------------
package cltlp_pkg;

   localparam int BYTE_W              = 8;
   localparam int CAP_W               = 13;
   localparam int CSR_DATA_W          = 32;
   localparam int CSR_ADDR_W          = 3;
   localparam int DEFAULT_ENTRY_DEPTH = 32;

   localparam logic [CAP_W-1:0]  CAPACITY_RESET = CAP_W'(256);
   localparam logic [CAP_W-1:0]  MIN_ROOM       = CAP_W'(2);
   localparam logic [BYTE_W-1:0] CHAR_SPACE     = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_COMMA     = 8'h2C;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // register index, taken from paddr above the byte offset
   localparam logic [CSR_ADDR_W-3:0] CSR_CAPACITY = '0;

   typedef struct packed {
      logic take_char;   // accepted list character
      logic emit_len;    // push the length byte
      logic emit_data;   // push the next buffered byte
      logic close_entry; // entry fully pushed
      logic emit_term;   // push the terminator and clear the list
   } dp_cmd_type;

   typedef struct packed {
      logic is_end;      // input item is the end marker
      logic char_closes; // input comma will close an entry
      logic entry_open;
      logic len_zero;
      logic data_last;   // the byte being pushed is the entry's last
      logic out_free;    // output register can take a byte
   } dp_status_type;

endpackage
`default_nettype wire

// ===== design/cltlp_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cltlp_req_if / cltlp_rsp_if
// Valid/ready channels for list characters in and encoded bytes out.
// ----------------------------------------------------------------------------
interface cltlp_req_if;
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic [cltlp_pkg::BYTE_W-1:0] in_char;

   modport source (output valid, output kind, output in_char, input ready);
   modport sink   (input valid, input kind, input in_char, output ready);
endinterface

interface cltlp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [cltlp_pkg::BYTE_W-1:0] out_byte;
   logic                         is_last;
   logic [cltlp_pkg::CAP_W-1:0]  total_count;
   logic                         overflow;

   modport source (output valid, output out_byte, output is_last, output total_count,
                   output overflow, input ready);
   modport sink   (input valid, input out_byte, input is_last, input total_count,
                   input overflow, output ready);
endinterface
`default_nettype wire

// ===== design/cltlp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cltlp_ctrl
// Sequencer: takes items while idle and walks the entry and terminator
// emission one byte per free output slot.
// ----------------------------------------------------------------------------
module cltlp_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  wire cltlp_pkg::dp_status_type status,
   output cltlp_pkg::dp_cmd_type     cmd
);
   import cltlp_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LEN,
      S_DATA,
      S_TERM
   } state_type;

   state_type state_ff, state_in;
   logic      term_pending_ff, term_pending_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in        = state_ff;
      term_pending_in = term_pending_ff;
      cmd             = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (status.is_end) begin
                  term_pending_in = 1'b1;
                  state_in        = status.entry_open ? S_LEN : S_TERM;
               end else begin
                  cmd.take_char = 1'b1;
                  if (status.char_closes) begin
                     state_in = S_LEN;
                  end
               end
            end
         end
         S_LEN: begin
            if (status.out_free) begin
               cmd.emit_len = 1'b1;
               if (status.len_zero) begin
                  cmd.close_entry = 1'b1;
                  state_in        = term_pending_ff ? S_TERM : S_IDLE;
               end else begin
                  state_in = S_DATA;
               end
            end
         end
         S_DATA: begin
            if (status.out_free) begin
               cmd.emit_data = 1'b1;
               if (status.data_last) begin
                  cmd.close_entry = 1'b1;
                  state_in        = term_pending_ff ? S_TERM : S_IDLE;
               end
            end
         end
         S_TERM: begin
            if (status.out_free) begin
               cmd.emit_term   = 1'b1;
               term_pending_in = 1'b0;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in        = S_IDLE;
            term_pending_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         term_pending_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         term_pending_ff <= term_pending_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/cltlp_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cltlp_datapath
// Entry buffer, capacity and count registers, and the output register.
// ----------------------------------------------------------------------------
module cltlp_datapath #(
   parameter int ENTRY_DEPTH = cltlp_pkg::DEFAULT_ENTRY_DEPTH
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_kind,
   input  wire [cltlp_pkg::BYTE_W-1:0]  req_in_char,
   input  wire                          cfg_write,
   input  wire [cltlp_pkg::CAP_W-1:0]   capacity,
   input  wire cltlp_pkg::dp_cmd_type   cmd,
   output cltlp_pkg::dp_status_type     status,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [cltlp_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                         rsp_is_last,
   output logic [cltlp_pkg::CAP_W-1:0]  rsp_total_count,
   output logic                         rsp_overflow
);
   import cltlp_pkg::*;

   localparam int LEN_W  = $clog2(ENTRY_DEPTH + 1);
   localparam int ADDR_W = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
   localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(ENTRY_DEPTH);

   logic [BYTE_W-1:0] entry_mem [ENTRY_DEPTH];

   logic [CAP_W-1:0]  remaining_ff, remaining_in;
   logic              open_ff, open_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [CAP_W-1:0]  written_ff, written_in;
   logic              ovf_seen_ff, ovf_seen_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic [BYTE_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              mem_we;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              last_ff, last_in;
   logic [CAP_W-1:0]  total_ff, total_in;
   logic              ovf_out_ff, ovf_out_in;

   logic              has_room, is_comma, skip_char;
   logic [LEN_W-1:0]  idx_plus;
   logic              push;

   assign has_room  = remaining_ff > MIN_ROOM;
   assign is_comma  = (req_in_char == CHAR_COMMA);
   assign skip_char = !open_ff && (req_in_char == CHAR_SPACE);
   assign idx_plus  = idx_ff + 1'b1;
   assign push      = cmd.emit_len || cmd.emit_data || cmd.emit_term;

   assign status.is_end      = (req_kind == KIND_END);
   assign status.char_closes = has_room && is_comma;
   assign status.entry_open  = open_ff;
   assign status.len_zero    = (len_ff == '0);
   assign status.data_last   = (idx_plus == len_ff);
   assign status.out_free    = !valid_ff || rsp_ready;

   // list state
   always_comb begin
      remaining_in = remaining_ff;
      open_in      = open_ff;
      len_in       = len_ff;
      written_in   = written_ff;
      ovf_seen_in  = ovf_seen_ff;
      idx_in       = idx_ff;
      mem_we       = 1'b0;
      if (cfg_write) begin
         remaining_in = capacity;
      end else if (cmd.emit_term) begin
         remaining_in = capacity;
         open_in      = 1'b0;
         len_in       = '0;
         written_in   = '0;
         ovf_seen_in  = 1'b0;
         idx_in       = '0;
      end else if (cmd.take_char && has_room && !skip_char) begin
         open_in = 1'b1;
         if (!open_ff) begin
            remaining_in = remaining_ff - 1'b1;
         end
         if (!is_comma) begin
            if (len_ff < DEPTH_L) begin
               mem_we       = 1'b1;
               len_in       = len_ff + 1'b1;
               remaining_in = open_ff ? remaining_ff - 1'b1 : remaining_ff - CAP_W'(2);
            end else begin
               ovf_seen_in = 1'b1;
            end
         end
      end else if (cmd.close_entry) begin
         written_in = written_ff + CAP_W'(len_ff) + 1'b1;
         open_in    = 1'b0;
         len_in     = '0;
         idx_in     = '0;
      end else if (cmd.emit_data) begin
         idx_in = idx_plus;
      end
   end

   // read address tracks the index that will hold after this edge
   always_comb begin
      if (idx_in < DEPTH_L) begin
         rd_addr = idx_in[ADDR_W-1:0];
      end else begin
         rd_addr = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[len_ff[ADDR_W-1:0]] <= req_in_char;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   // output register
   always_comb begin
      valid_in   = valid_ff;
      byte_in    = byte_ff;
      last_in    = last_ff;
      total_in   = total_ff;
      ovf_out_in = ovf_out_ff;
      if (push) begin
         valid_in   = 1'b1;
         last_in    = 1'b0;
         total_in   = '0;
         ovf_out_in = 1'b0;
         if (cmd.emit_len) begin
            byte_in = BYTE_W'(len_ff);
         end else if (cmd.emit_data) begin
            byte_in = rd_data_ff;
         end else begin
            byte_in    = '0;
            last_in    = 1'b1;
            total_in   = written_ff;
            ovf_out_in = ovf_seen_ff;
         end
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= CAPACITY_RESET;
         open_ff      <= 1'b0;
         len_ff       <= '0;
         written_ff   <= '0;
         ovf_seen_ff  <= 1'b0;
         idx_ff       <= '0;
         valid_ff     <= 1'b0;
      end else begin
         remaining_ff <= remaining_in;
         open_ff      <= open_in;
         len_ff       <= len_in;
         written_ff   <= written_in;
         ovf_seen_ff  <= ovf_seen_in;
         idx_ff       <= idx_in;
         valid_ff     <= valid_in;
      end
      byte_ff    <= byte_in;
      last_ff    <= last_in;
      total_ff   <= total_in;
      ovf_out_ff <= ovf_out_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_is_last     = last_ff;
   assign rsp_total_count = total_ff;
   assign rsp_overflow    = ovf_out_ff;

endmodule
`default_nettype wire

// ===== design/comma_list_to_length_prefixed_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// comma_list_to_length_prefixed_unit
// Encodes a comma-separated name list as length-prefixed entries ending in
// a zero byte, with a capacity register on an APB-style port.
// ----------------------------------------------------------------------------
// a character is taken while the controller is idle; a closing comma or end item
//   starts emission, and each byte is registered into the output register,
//   1 byte per cycle while it is free; no new item is taken until the
//   entry buffer is read out through the single output register
// reset: synchronous; capacity back to 256, list state cleared, no clearing pass
// ----------------------------------------------------------------------------
module comma_list_to_length_prefixed_unit #(
   parameter int ENTRY_DEPTH = cltlp_pkg::DEFAULT_ENTRY_DEPTH
) (
   input  wire                                clock,
   input  wire                                reset,
   cltlp_req_if.sink                          req_bus,
   cltlp_rsp_if.source                        rsp_bus,
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire [cltlp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire [cltlp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [cltlp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                               csr_pready
);
   import cltlp_pkg::*;

   logic [CAP_W-1:0]        capacity_ff, capacity_in;
   logic                    cfg_write;
   logic [CSR_ADDR_W-3:0]   csr_index;
   dp_cmd_type              cmd;
   dp_status_type           status;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_index == CSR_CAPACITY);

   always_comb begin
      if (csr_index == CSR_CAPACITY) begin
         csr_prdata = CSR_DATA_W'(capacity_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   // the datapath reloads its budget from the value that holds after this edge
   always_comb begin
      if (cfg_write) begin
         capacity_in = csr_pwdata[CAP_W-1:0];
      end else begin
         capacity_in = capacity_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   cltlp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cltlp_datapath #(
      .ENTRY_DEPTH (ENTRY_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_kind        (req_bus.kind),
      .req_in_char     (req_bus.in_char),
      .cfg_write       (cfg_write),
      .capacity        (capacity_in),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_out_byte    (rsp_bus.out_byte),
      .rsp_is_last     (rsp_bus.is_last),
      .rsp_total_count (rsp_bus.total_count),
      .rsp_overflow    (rsp_bus.overflow)
   );

   // terminator is always a zero byte
   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.is_last |-> rsp_bus.out_byte == '0)
      else $error("terminator byte not zero");

   // count and flag only travel with the terminator
   a_info_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.is_last |->
         rsp_bus.total_count == '0 && !rsp_bus.overflow)
      else $error("count or overflow on a non-final byte");

   // no new item is taken while a byte push is under way
   a_no_take_while_emit: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_len || cmd.emit_data || cmd.emit_term) |-> !req_bus.ready)
      else $error("input taken during emission");

   // a byte is only pushed into a free output slot
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_len || cmd.emit_data || cmd.emit_term) |-> status.out_free)
      else $error("output register overwritten");

endmodule
`default_nettype wire
